// ===== src/assert_macros.svh =====
// Assertion helpers for the engine top level, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a implies property b in the same cycle.
`define ASSERT_IMPL(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");

// Property a implies b at the next edge.
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/spfa_pkg.sv =====
`default_nettype none
package spfa_pkg;

    localparam int MAX_NODES  = 64;
    localparam int MAX_EDGES  = 1024;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int EDGE_W     = $clog2(MAX_EDGES);
    localparam int ECNT_W     = EDGE_W + 1;
    localparam int CNT_W      = NODE_W + 1;
    localparam int DIST_W     = 23;
    localparam int WEIGHT_W   = 16;
    localparam int EDGE_REC_W = 6 + WEIGHT_W + ECNT_W;
    localparam logic [DIST_W-1:0] DIST_INF = 23'h7FFFFF;
    localparam logic [DIST_W-1:0] DIST_MAX = 23'h3FFFFF;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  node;
        logic [21:0] distance;
        logic        reachable;
        logic        last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_INIT, ST_POP, ST_POP_WAIT, ST_EDGE_RD, ST_EDGE_WAIT,
        ST_RELAX, ST_OUT_RD, ST_OUT_WAIT, ST_OUT_HOLD, ST_ADD
    } state_t;

    typedef struct packed {
        logic do_clear;
        logic do_add;
        logic add_wr;
        logic init_start;
        logic init_step;
        logic pop;
        logic head_rd;
        logic relax;
        logic out_start;
        logic out_rd;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic init_done;
        logic src_valid;
        logic queue_empty;
        logic list_end;
        logic out_done;
    } status_t;

endpackage
`default_nettype wire

// ===== src/spfa_ram.sv =====
`default_nettype none
module spfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/spfa_ctrl.sv =====
`default_nettype none
module spfa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_fire,
    input  wire logic [1:0]         in_action,
    input  wire logic               out_free,
    input  wire spfa_pkg::status_t  status,
    output spfa_pkg::cmd_t          cmd,
    output logic                    s_ready_o
);
    import spfa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire && in_action == ACT_RUN) state_next = ST_INIT;
                else if (in_fire && in_action == ACT_ADD) state_next = ST_ADD;
            end
            ST_ADD:       state_next = ST_IDLE;
            ST_INIT: begin
                if (status.init_done) state_next = status.src_valid ? ST_POP : ST_OUT_RD;
            end
            ST_POP: begin
                state_next = status.queue_empty ? ST_OUT_RD : ST_POP_WAIT;
            end
            ST_POP_WAIT:  state_next = ST_EDGE_RD;
            ST_EDGE_RD: begin
                state_next = status.list_end ? ST_POP : ST_EDGE_WAIT;
            end
            ST_EDGE_WAIT: state_next = ST_RELAX;
            ST_RELAX:     state_next = ST_EDGE_RD;
            ST_OUT_RD:    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:  state_next = ST_OUT_HOLD;
            ST_OUT_HOLD: begin
                if (out_free) state_next = status.out_done ? ST_IDLE : ST_OUT_RD;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready_o = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready_o = 1'b1;
                cmd.do_clear   = in_fire && in_action == ACT_CLEAR;
                cmd.do_add     = in_fire && in_action == ACT_ADD;
                cmd.init_start = in_fire && in_action == ACT_RUN;
            end
            ST_ADD:       cmd.add_wr = 1'b1;
            ST_INIT:      cmd.init_step = 1'b1;
            ST_POP: begin
                cmd.pop = !status.queue_empty;
                cmd.out_start = status.queue_empty;
            end
            ST_POP_WAIT:  cmd.head_rd = 1'b1;
            ST_RELAX:     cmd.relax = 1'b1;
            ST_OUT_RD:    cmd.out_rd = 1'b1;
            ST_OUT_WAIT:  cmd.out_rd = 1'b1;
            ST_OUT_HOLD: begin
                cmd.out_rd = 1'b1;
                cmd.out_load = out_free;
            end
            default:      cmd = '0;
        endcase
        if (state_reg == ST_INIT && status.init_done && !status.src_valid) begin
            cmd.out_start = 1'b1;
        end
    end
endmodule
`default_nettype wire

// ===== src/spfa_dp.sv =====
`default_nettype none
module spfa_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire spfa_pkg::in_item_t  in_item,
    input  wire logic [6:0]          node_count,
    input  wire spfa_pkg::cmd_t      cmd,
    output spfa_pkg::status_t        status,
    output spfa_pkg::out_item_t      out_item
);
    import spfa_pkg::*;

    logic                head_valid_reg [MAX_NODES];
    logic [ECNT_W-1:0]   edge_total_reg;
    logic                marks_reg [MAX_NODES];
    logic [CNT_W-1:0]    n_reg;
    logic [NODE_W-1:0]   src_reg;
    logic                src_ok_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [NODE_W-1:0]   q_head_reg, q_tail_reg;
    logic [CNT_W-1:0]    q_fill_reg;
    logic [NODE_W-1:0]   u_reg;
    logic [ECNT_W-1:0]   k_reg;
    logic [NODE_W-1:0]   a_from_reg, a_to_reg;
    logic [WEIGHT_W-1:0] a_wt_reg;
    logic                du_pending_reg;
    logic [DIST_W-1:0]   du_cap_reg;

    // Edge store: destination, weight and next link.
    logic                  e_we;
    logic [EDGE_W-1:0]     e_waddr;
    logic [EDGE_REC_W-1:0] e_wdata, e_rdata;
    // List heads; an entry counts only once its valid flag is set.
    logic [NODE_W-1:0] h_raddr;
    logic [ECNT_W-1:0] h_rdata, head_link;
    // Distance memory.
    logic              d_we;
    logic [NODE_W-1:0] d_waddr, d_raddr;
    logic [DIST_W-1:0] d_wdata, d_rdata;
    // Work queue.
    logic              q_we;
    logic [NODE_W-1:0] q_wdata, q_rdata;

    logic [NODE_W-1:0] e_dest;
    logic [15:0]       e_wt;
    logic [ECNT_W-1:0] e_next;
    logic [DIST_W:0]   cand_sum;
    logic [DIST_W-1:0] cand;
    logic [DIST_W-1:0] dv_cur;
    logic              improve;
    logic              add_ok;
    logic [CNT_W-1:0]  n_eff;

    assign {e_dest, e_wt, e_next} = e_rdata;
    assign add_ok = edge_total_reg < ECNT_W'(MAX_EDGES);

    always_comb begin
        if (node_count < 7'd2) n_eff = CNT_W'(2);
        else if (node_count > 7'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
        else n_eff = CNT_W'(node_count);
    end

    spfa_ram #(.WIDTH(EDGE_REC_W), .DEPTH(MAX_EDGES)) u_edges (
        .aclk(aclk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(k_reg[EDGE_W-1:0]), .rdata(e_rdata)
    );
    spfa_ram #(.WIDTH(ECNT_W), .DEPTH(MAX_NODES)) u_heads (
        .aclk(aclk), .we(e_we), .waddr(a_from_reg), .wdata(edge_total_reg),
        .raddr(h_raddr), .rdata(h_rdata)
    );
    spfa_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );
    spfa_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
        .aclk(aclk), .we(q_we), .waddr(q_tail_reg), .wdata(q_wdata),
        .raddr(q_head_reg), .rdata(q_rdata)
    );

    // The head of the source list is read as the add beat is accepted and used in the next cycle, in ADD.
    assign h_raddr   = cmd.pop ? q_rdata : in_item.from_node;
    assign head_link = head_valid_reg[a_from_reg] ? h_rdata : ECNT_W'(MAX_EDGES);

    assign e_we    = cmd.add_wr && add_ok;
    assign e_waddr = edge_total_reg[EDGE_W-1:0];
    assign e_wdata = {a_to_reg, a_wt_reg, head_link};

    // The edge read lands in EDGE_WAIT and the distance of its destination in RELAX.
    assign cand_sum = {1'b0, du_cap_reg} + (DIST_W+1)'(e_wt);
    assign cand     = (cand_sum > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : cand_sum[DIST_W-1:0];
    assign dv_cur   = d_rdata;
    assign improve  = (CNT_W'(e_dest) < n_reg) && (dv_cur > cand);

    always_comb begin
        d_we = 1'b0;
        d_waddr = cnt_reg[NODE_W-1:0];
        d_wdata = DIST_INF;
        d_raddr = e_dest;
        q_we = 1'b0;
        q_wdata = e_dest;
        if (cmd.init_step) begin
            d_we = 1'b1;
            if (cnt_reg[NODE_W-1:0] == src_reg && src_ok_reg) d_wdata = '0;
            // The source goes in early so that its entry can be read by the first pop.
            if (cnt_reg == '0 && src_ok_reg) begin
                q_we = 1'b1;
                q_wdata = src_reg;
            end
        end else if (cmd.relax && improve) begin
            d_we = 1'b1;
            d_waddr = e_dest;
            d_wdata = cand;
            q_we = !marks_reg[e_dest];
        end
        if (cmd.head_rd) d_raddr = u_reg;
        if (cmd.out_rd) d_raddr = cnt_reg[NODE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                head_valid_reg[i] <= 1'b0;
                marks_reg[i] <= 1'b0;
            end
            edge_total_reg <= '0;
            cnt_reg <= '0;
            q_head_reg <= '0;
            q_tail_reg <= '0;
            q_fill_reg <= '0;
        end else begin
            if (cmd.do_clear) begin
                for (int i = 0; i < MAX_NODES; i++) head_valid_reg[i] <= 1'b0;
                edge_total_reg <= '0;
            end
            if (e_we) begin
                head_valid_reg[a_from_reg] <= 1'b1;
                edge_total_reg <= edge_total_reg + 1'b1;
            end
            if (cmd.init_start) begin
                cnt_reg <= '0;
                q_head_reg <= '0;
                q_tail_reg <= '0;
                q_fill_reg <= '0;
                for (int i = 0; i < MAX_NODES; i++) marks_reg[i] <= 1'b0;
            end
            if (cmd.init_step) cnt_reg <= cnt_reg + 1'b1;
            if (q_we) begin
                q_tail_reg <= q_tail_reg + 1'b1;
                marks_reg[q_wdata] <= 1'b1;
            end
            if (cmd.pop) begin
                q_head_reg <= q_head_reg + 1'b1;
                marks_reg[q_rdata] <= 1'b0;
            end
            q_fill_reg <= q_fill_reg + CNT_W'(q_we) - CNT_W'(cmd.pop);
            if (cmd.out_start) cnt_reg <= '0;
            if (cmd.out_load) cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // The queue read is registered, so the head entry is valid in POP.
    always_ff @(posedge aclk) begin
        if (cmd.do_add) begin
            a_from_reg <= in_item.from_node;
            a_to_reg   <= in_item.to_node;
            a_wt_reg   <= in_item.weight;
        end
        if (cmd.init_start) begin
            n_reg <= n_eff;
            src_reg <= in_item.from_node;
            src_ok_reg <= CNT_W'(in_item.from_node) < n_eff;
        end
        if (cmd.pop) u_reg <= q_rdata;
        if (cmd.head_rd) k_reg <= head_valid_reg[u_reg] ? h_rdata : ECNT_W'(MAX_EDGES);
        if (cmd.relax) k_reg <= e_next;
    end

    // The distance of u is read once per pop; it cannot fall while its own edges are walked.
    always_ff @(posedge aclk) begin
        if (!aresetn) du_pending_reg <= 1'b0;
        else du_pending_reg <= cmd.head_rd;
    end
    always_ff @(posedge aclk) begin
        if (du_pending_reg) du_cap_reg <= d_rdata;
    end

    always_comb begin
        status.init_done   = cnt_reg == CNT_W'(MAX_NODES - 1);
        status.src_valid   = src_ok_reg;
        status.queue_empty = q_fill_reg == '0;
        status.list_end    = !(k_reg < edge_total_reg && k_reg < ECNT_W'(MAX_EDGES));
        status.out_done    = cnt_reg + 1'b1 == n_reg;
    end

    always_comb begin
        out_item.node      = cnt_reg[NODE_W-1:0];
        out_item.reachable = d_rdata != DIST_INF;
        out_item.distance  = (d_rdata != DIST_INF) ? d_rdata[21:0] : 22'd0;
        out_item.last      = cnt_reg + 1'b1 == n_reg;
    end
endmodule
`default_nettype wire

// ===== src/spfa_shortest_path_engine.sv =====
// Clear acts on its beat and add passes ADD; the next beat is taken once the edge is written.
// A run initialises all 64 distance entries; each pop passes POP, POP_WAIT and EDGE_RD, each
// edge EDGE_WAIT, RELAX and EDGE_RD, and each result node OUT_RD, OUT_WAIT and OUT_HOLD.
// Input is held off until the last result has been loaded into the output register.
// The edge store, list heads, distances and queue sit in RAMs with registered reads.
// Reset (synchronous, active low) empties the graph and sets node_count to 64.
`default_nettype none
`include "assert_macros.svh"
module spfa_shortest_path_engine (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire spfa_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output spfa_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [6:0]          cfg_data
);
    import spfa_pkg::*;

    cmd_t      cmd;
    status_t   status;
    out_item_t res;
    logic      in_fire;
    logic      out_free;
    logic [6:0] node_count_reg;

    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid || m_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) node_count_reg <= 7'd64;
        else if (cfg_valid) node_count_reg <= cfg_data;
    end

    spfa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .in_action(s_data.action),
        .out_free(out_free), .status(status), .cmd(cmd), .s_ready_o(s_ready)
    );

    spfa_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data), .node_count(node_count_reg),
        .cmd(cmd), .status(status), .out_item(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_data <= res;
    end

    `ASSERT_IMPL(a_no_load_blocked, aclk, aresetn, cmd.out_load, out_free)
    `ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, m_valid && !m_ready, !cmd.out_load)
    `ASSERT_NEXT(a_run_blocks, aclk, aresetn, cmd.init_start, !s_ready)
endmodule
`default_nettype wire
